// ----- rtl/dsht_pkg.sv -----
package dsht_pkg;

  localparam int ROW_BYTES      = 8192;
  localparam int LINE_BYTES     = 64;
  localparam int LINES_PER_ROW  = 128;
  localparam int MAX_RECORDS    = 32;

  localparam int WORDS_PER_LINE = LINE_BYTES / 4;
  localparam int ROW_WORDS      = LINES_PER_ROW * WORDS_PER_LINE;
  localparam int LINE_SHIFT     = $clog2(LINE_BYTES);
  localparam int WPL_SHIFT      = $clog2(WORDS_PER_LINE);
  localparam int LINE_W         = (LINES_PER_ROW > 1) ? $clog2(LINES_PER_ROW) : 1;
  localparam int IDX_W          = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int MC_W           = $clog2(ROW_WORDS + 1);
  localparam int BF_W           = $clog2(ROW_WORDS * 32 + 1);
  localparam int RC_W           = $clog2(MAX_RECORDS + 1);

  // op queue between front and back
  localparam int OPQ_DEPTH      = 4;
  localparam int OPQ_PTR_W      = $clog2(OPQ_DEPTH);
  localparam int OPQ_CNT_W      = $clog2(OPQ_DEPTH + 1);

  // result queue in the back end
  localparam int RQ_DEPTH       = 4;
  localparam int RQ_PTR_W       = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W       = $clog2(RQ_DEPTH + 1);

  // input modes, also used as op codes in the queue
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_WORD  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_IDLE    = 3'd0;
  localparam logic [2:0] KIND_WRITE   = 3'd1;
  localparam logic [2:0] KIND_READ    = 3'd2;
  localparam logic [2:0] KIND_FLIP    = 3'd3;
  localparam logic [2:0] KIND_SUMMARY = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_VICTIM    = 2'd0;
  localparam logic [1:0] CFG_ITER      = 2'd1;
  localparam logic [1:0] CFG_PATTERN   = 2'd2;
  localparam logic [1:0] CFG_SERIALIZE = 2'd3;

  typedef struct packed {
    logic [1:0]  code;
    logic [31:0] word;
  } op_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [31:0] line_data;
    logic        wait_after;
    logic [6:0]  line_index;
    logic [3:0]  word_slot;
    logic [31:0] expected_word;
    logic [31:0] actual_word;
    logic [11:0] flipped_words;
    logic [16:0] flipped_bits;
    logic [32:0] activations;
    logic        last;
  } res_t;

  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      n = n + 6'(v[i]);
    end
    return n;
  endfunction

endpackage

// ----- rtl/dsht_if.sv -----
interface dsht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] read_word;

  modport source (output valid, output mode, output read_word, input ready);
  modport sink   (input valid, input mode, input read_word, output ready);
endinterface

interface dsht_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] address;
  logic [31:0] line_data;
  logic        wait_after;
  logic [6:0]  line_index;
  logic [3:0]  word_slot;
  logic [31:0] expected_word;
  logic [31:0] actual_word;
  logic [11:0] flipped_words;
  logic [16:0] flipped_bits;
  logic [32:0] activations;
  logic        last;

  modport source (output valid, output kind, output address, output line_data,
                  output wait_after, output line_index, output word_slot,
                  output expected_word, output actual_word, output flipped_words,
                  output flipped_bits, output activations, output last,
                  input ready);
  modport sink   (input valid, input kind, input address, input line_data,
                  input wait_after, input line_index, input word_slot,
                  input expected_word, input actual_word, input flipped_words,
                  input flipped_bits, input activations, input last,
                  output ready);
endinterface

interface dsht_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/double_sided_hammer_test_sequencer.sv -----
// channel  dir  handshake     beat contents
// req      in   valid/ready   mode, read_word
// rsp      out  valid/ready   kind, address, line_data, wait_after, line_index,
//                             word_slot, expected_word, actual_word,
//                             flipped_words, flipped_bits, activations, last
// cfg      in   valid/ready   index, data (ready is always high)
//
// One req beat per cycle while the op queue has room. A req beat is stored in the op queue
// and its result in the result queue before the result is valid on rsp; a final read-back
// word with a mismatch, while flip records remain, gives two rsp beats.
// Throughput is set by the result queue: the back end takes an op only when the
// four-entry result queue has two free slots. req.ready drops when the four-entry op
// queue is full. Reset (rst, synchronous) empties both queues, idles the sequencer
// and clears the configuration registers.
module double_sided_hammer_test_sequencer (
  input logic          clk,
  input logic          rst,
  dsht_req_if.sink     req,
  dsht_rsp_if.source   rsp,
  dsht_cfg_if.sink     cfg
);
  import dsht_pkg::*;

  logic op_valid;
  logic op_pop;
  op_t  op;

  dsht_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop)
  );

  dsht_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop),
    .cfg      (cfg),
    .rsp      (rsp)
  );

endmodule

// ----- rtl/dsht_front.sv -----
module dsht_front (
  input  logic          clk,
  input  logic          rst,
  dsht_req_if.sink      req,
  output logic          op_valid,
  output dsht_pkg::op_t op,
  input  logic          op_pop
);
  import dsht_pkg::*;

  op_t                  opq [0:OPQ_DEPTH-1];
  logic [OPQ_PTR_W-1:0] wptr;
  logic [OPQ_PTR_W-1:0] rptr;
  logic [OPQ_CNT_W-1:0] count;
  logic                 push;
  op_t                  in_op;

  assign req.ready = (count != OPQ_CNT_W'(OPQ_DEPTH));
  // mode 3 beats are taken and dropped here
  assign push = req.valid && req.ready && (req.mode != MODE_NONE);

  always_comb begin
    in_op.code = req.mode;
    in_op.word = (req.mode == MODE_WORD) ? req.read_word : '0;
  end

  assign op_valid = (count != '0);
  assign op       = opq[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      opq[wptr] <= in_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (op_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + OPQ_CNT_W'(push) - OPQ_CNT_W'(op_pop);
    end
  end

endmodule

// ----- rtl/dsht_back.sv -----
module dsht_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  input  dsht_pkg::op_t op,
  output logic          op_pop,
  dsht_cfg_if.sink      cfg,
  dsht_rsp_if.source    rsp
);
  import dsht_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_FILL   = 3'd1;
  localparam logic [2:0] PH_AGGR   = 3'd2;
  localparam logic [2:0] PH_HAMMER = 3'd3;
  localparam logic [2:0] PH_VERIFY = 3'd4;

  // configuration
  logic [31:0] victim_address;
  logic [31:0] hammer_iterations;
  logic [31:0] fill_pattern;
  logic        serialize_reads;

  // sequencer and checker state
  logic [2:0]        phase, phase_next;
  logic [LINE_W-1:0] line_counter, line_counter_next;
  logic              side_toggle, side_toggle_next;
  logic [31:0]       hammer_counter, hammer_counter_next;
  logic [IDX_W-1:0]  readback_counter, readback_counter_next;
  logic [MC_W-1:0]   mismatch_count, mismatch_count_next;
  logic [BF_W-1:0]   bit_flip_count, bit_flip_count_next;
  logic [RC_W-1:0]   record_count, record_count_next;
  logic              armed, armed_next;

  // tick datapath
  logic [2:0]        eff_phase;
  logic [LINE_W-1:0] eff_line;
  logic              eff_toggle;
  logic              lastline;
  logic [31:0]       off;
  logic [31:0]       lo_row;
  logic [31:0]       hi_row;
  logic              fin;

  // word datapath
  logic              word_mis;
  logic              word_final;
  logic [5:0]        diff_bits;
  logic [MC_W-1:0]   mc_inc;
  logic [BF_W-1:0]   bf_inc;
  res_t              flip_res;
  res_t              sum_res;

  // results for this op
  res_t              res0, res1;
  logic [1:0]        n_res;
  logic              summary_push;

  // result queue
  res_t                rq [0:RQ_DEPTH-1];
  logic [RQ_PTR_W-1:0] rq_wptr, rq_rptr, rq_wptr_inc;
  logic [RQ_CNT_W-1:0] rq_count;
  logic                out_pop;
  res_t                head;

  assign cfg.ready = 1'b1;

  // room for two results before an op is taken
  assign op_pop = op_valid && (rq_count <= RQ_CNT_W'(RQ_DEPTH - 2));

  assign lo_row = victim_address - 32'(ROW_BYTES);
  assign hi_row = victim_address + 32'(ROW_BYTES);

  assign word_mis   = (op.word != fill_pattern);
  assign diff_bits  = popcount32(op.word ^ fill_pattern);
  assign mc_inc     = mismatch_count + 1'b1;
  assign bf_inc     = bit_flip_count + BF_W'(diff_bits);
  assign word_final = (readback_counter == IDX_W'(ROW_WORDS - 1));

  always_comb begin
    flip_res               = '0;
    flip_res.kind          = KIND_FLIP;
    flip_res.line_index    = 7'(readback_counter >> WPL_SHIFT);
    flip_res.word_slot     = 4'(readback_counter & IDX_W'(WORDS_PER_LINE - 1));
    flip_res.expected_word = fill_pattern;
    flip_res.actual_word   = op.word;
    flip_res.last          = !word_final;

    sum_res               = '0;
    sum_res.kind          = KIND_SUMMARY;
    sum_res.flipped_words = 12'(word_mis ? mc_inc : mismatch_count);
    sum_res.flipped_bits  = 17'(word_mis ? bf_inc : bit_flip_count);
    sum_res.activations   = {hammer_iterations, 1'b0};
    sum_res.last          = 1'b1;
  end

  always_comb begin
    eff_phase  = phase;
    eff_line   = line_counter;
    eff_toggle = side_toggle;
    // hammer count reached (or iterations lowered): fall through to victim reads
    if (phase == PH_HAMMER && hammer_counter >= hammer_iterations) begin
      eff_phase  = PH_VERIFY;
      eff_line   = '0;
      eff_toggle = 1'b0;
    end
    lastline = (eff_line == LINE_W'(LINES_PER_ROW - 1));
    off      = 32'(eff_line) << LINE_SHIFT;
    fin      = eff_toggle &&
               (({1'b0, hammer_counter} + 33'd1) >= {1'b0, hammer_iterations});
  end

  always_comb begin
    phase_next            = phase;
    line_counter_next     = line_counter;
    side_toggle_next      = side_toggle;
    hammer_counter_next   = hammer_counter;
    readback_counter_next = readback_counter;
    mismatch_count_next   = mismatch_count;
    bit_flip_count_next   = bit_flip_count;
    record_count_next     = record_count;
    armed_next            = armed;
    res0                  = '0;
    res1                  = '0;
    n_res                 = 2'd0;
    summary_push          = 1'b0;

    if (op_pop) begin
      case (op.code)
        MODE_START: begin
          phase_next            = PH_FILL;
          line_counter_next     = '0;
          side_toggle_next      = 1'b0;
          hammer_counter_next   = '0;
          readback_counter_next = '0;
          mismatch_count_next   = '0;
          bit_flip_count_next   = '0;
          record_count_next     = '0;
          armed_next            = 1'b1;
        end
        MODE_TICK: begin
          phase_next        = eff_phase;
          line_counter_next = eff_line;
          side_toggle_next  = eff_toggle;
          n_res             = 2'd1;
          res0.last         = 1'b1;
          case (eff_phase)
            PH_FILL: begin
              res0.kind         = KIND_WRITE;
              res0.address      = victim_address + off;
              res0.line_data    = fill_pattern;
              res0.wait_after   = lastline;
              line_counter_next = eff_line + 1'b1;
              if (lastline) begin
                phase_next        = PH_AGGR;
                line_counter_next = '0;
                side_toggle_next  = 1'b0;
              end
            end
            PH_AGGR: begin
              res0.kind       = KIND_WRITE;
              res0.address    = (eff_toggle ? hi_row : lo_row) + off;
              res0.line_data  = ~fill_pattern;
              res0.wait_after = lastline && eff_toggle;
              side_toggle_next = !eff_toggle;
              if (eff_toggle) begin
                line_counter_next = eff_line + 1'b1;
                if (lastline) begin
                  phase_next          = PH_HAMMER;
                  line_counter_next   = '0;
                  hammer_counter_next = '0;
                end
              end
            end
            PH_HAMMER: begin
              res0.kind        = KIND_READ;
              res0.address     = eff_toggle ? hi_row : lo_row;
              res0.wait_after  = serialize_reads || fin;
              side_toggle_next = !eff_toggle;
              if (eff_toggle) begin
                hammer_counter_next = hammer_counter + 1'b1;
              end
            end
            PH_VERIFY: begin
              res0.kind         = KIND_READ;
              res0.address      = victim_address + off;
              res0.wait_after   = 1'b1;
              line_counter_next = eff_line + 1'b1;
              if (lastline) begin
                phase_next        = PH_IDLE;
                line_counter_next = '0;
              end
            end
            default: begin
              res0.kind = KIND_IDLE;
            end
          endcase
        end
        MODE_WORD: begin
          if (armed) begin
            if (word_mis) begin
              mismatch_count_next = mc_inc;
              bit_flip_count_next = bf_inc;
              if (record_count < RC_W'(MAX_RECORDS)) begin
                res0              = flip_res;
                n_res             = 2'd1;
                record_count_next = record_count + 1'b1;
              end
            end
            readback_counter_next = readback_counter + 1'b1;
            if (word_final) begin
              summary_push = 1'b1;
              armed_next   = 1'b0;
              if (n_res == 2'd1) begin
                res1  = sum_res;
                n_res = 2'd2;
              end else begin
                res0  = sum_res;
                n_res = 2'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      victim_address    <= '0;
      hammer_iterations <= '0;
      fill_pattern      <= '0;
      serialize_reads   <= 1'b0;
      phase             <= PH_IDLE;
      line_counter      <= '0;
      side_toggle       <= 1'b0;
      hammer_counter    <= '0;
      readback_counter  <= '0;
      mismatch_count    <= '0;
      bit_flip_count    <= '0;
      record_count      <= '0;
      armed             <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_VICTIM:    victim_address    <= cfg.data;
          CFG_ITER:      hammer_iterations <= cfg.data;
          CFG_PATTERN:   fill_pattern      <= cfg.data;
          CFG_SERIALIZE: serialize_reads   <= cfg.data[0];
          default: begin
          end
        endcase
      end
      phase            <= phase_next;
      line_counter     <= line_counter_next;
      side_toggle      <= side_toggle_next;
      hammer_counter   <= hammer_counter_next;
      readback_counter <= readback_counter_next;
      mismatch_count   <= mismatch_count_next;
      bit_flip_count   <= bit_flip_count_next;
      record_count     <= record_count_next;
      armed            <= armed_next;
    end
  end

  // result queue: up to two writes per cycle, one read
  assign rq_wptr_inc = rq_wptr + 1'b1;
  assign out_pop     = rsp.valid && rsp.ready;
  assign head        = rq[rq_rptr];

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      rq[rq_wptr] <= res0;
    end
    if (n_res == 2'd2) begin
      rq[rq_wptr_inc] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wptr  <= '0;
      rq_rptr  <= '0;
      rq_count <= '0;
    end else begin
      rq_wptr <= rq_wptr + RQ_PTR_W'(n_res);
      if (out_pop) begin
        rq_rptr <= rq_rptr + 1'b1;
      end
      rq_count <= rq_count + RQ_CNT_W'(n_res) - RQ_CNT_W'(out_pop);
    end
  end

  assign rsp.valid         = (rq_count != '0);
  assign rsp.kind          = head.kind;
  assign rsp.address       = head.address;
  assign rsp.line_data     = head.line_data;
  assign rsp.wait_after    = head.wait_after;
  assign rsp.line_index    = head.line_index;
  assign rsp.word_slot     = head.word_slot;
  assign rsp.expected_word = head.expected_word;
  assign rsp.actual_word   = head.actual_word;
  assign rsp.flipped_words = head.flipped_words;
  assign rsp.flipped_bits  = head.flipped_bits;
  assign rsp.activations   = head.activations;
  assign rsp.last          = head.last;

  a_rq_bound: assert property (@(posedge clk) disable iff (rst)
    rq_count <= RQ_CNT_W'(RQ_DEPTH))
    else $error("result queue overflow");

  a_rec_bound: assert property (@(posedge clk) disable iff (rst)
    record_count <= RC_W'(MAX_RECORDS))
    else $error("flip record count past limit");

  a_idle_line: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> line_counter == '0)
    else $error("line counter not cleared in idle");

  a_toggle_side: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FILL || phase == PH_VERIFY) |-> !side_toggle)
    else $error("side toggle set outside aggressor phases");

  a_disarm: assert property (@(posedge clk) disable iff (rst)
    summary_push |=> !armed && readback_counter == '0)
    else $error("read-back still armed after summary");

endmodule
